// File: rtl/crsm_pkg.sv
// Shared types and constants for the contiguous ring space manager.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crsm_pkg;

	// field widths
	localparam int LEN_W    = 13;
	localparam int OFF_W    = 12;
	localparam int POS_W    = 13;
	localparam int NEED_W   = 14;
	localparam int MARK_W   = 7;
	localparam int LOST_W   = 32;
	localparam int MSG_W    = 16;
	localparam int CFG_W    = 13;
	localparam int CIDX_W   = 1;

	// reset values and limits
	localparam int DEPTH_DEF  = 4096;
	localparam int CAP_RESET  = 4096;
	localparam int MARK_RESET = 32;
	localparam int MARK_MAX   = 64;

	// result kinds
	localparam logic [1:0] RK_WRITE = 2'd0;
	localparam logic [1:0] RK_MARK  = 2'd1;
	localparam logic [1:0] RK_READ  = 2'd2;
	localparam logic [1:0] RK_NONE  = 2'd3;

	// request kinds
	localparam logic KIND_APPEND = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_CAPACITY = 1'd0;
	localparam logic [CIDX_W-1:0] REG_MARKER   = 1'd1;

	typedef struct packed {
		logic             kind;
		logic [LEN_W-1:0] length;
		logic             reserve_extra;
	} req_t;

	typedef struct packed {
		logic [1:0]        result_kind;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  seg_length;
		logic [LOST_W-1:0] lost_byte_count;
		logic [LEN_W-1:0]  fill_level;
		logic              last;
	} res_t;

	// datapath operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_EMPTY,
		OP_MARK,
		OP_APPEND,
		OP_READ
	} op_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		op_t  op;
		logic slot;
		logic sel;
		logic last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic len_zero;
		logic is_read;
		logic fill_zero;
		logic lost_nz;
		logic mark_fits;
		logic two_seg;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/crsm_ctrl.sv
// Sequencer for the ring space manager: accepts one item, steps the datapath
// through marker, append or read, then presents one or two results. Uses crsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crsm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire crsm_pkg::sts_t sts,
	output crsm_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_APPEND,
		ST_OUT0,
		ST_OUT1
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   sel_q;
	logic   last_q;
	logic   one_res;
	crsm_pkg::op_t op;
	logic   slot;

	// operation for this cycle
	always_comb begin
		op      = crsm_pkg::OP_IDLE;
		slot    = 1'b0;
		one_res = 1'b1;
		unique case (state_q)
			ST_DECIDE: begin
				if (sts.len_zero || (sts.is_read && sts.fill_zero)) begin
					op = crsm_pkg::OP_EMPTY;
				end else if (sts.is_read) begin
					op      = crsm_pkg::OP_READ;
					one_res = !sts.two_seg;
				end else if (sts.lost_nz) begin
					op      = crsm_pkg::OP_MARK;
					one_res = !sts.mark_fits;
				end else begin
					op = crsm_pkg::OP_APPEND;
				end
			end
			ST_APPEND: begin
				op   = crsm_pkg::OP_APPEND;
				slot = 1'b1;
			end
			default: begin
				op = crsm_pkg::OP_IDLE;
			end
		endcase
	end

	assign cmd.load  = in_valid && in_ready_q;
	assign cmd.op    = op;
	assign cmd.slot  = slot;
	assign cmd.sel   = sel_q;
	assign cmd.last  = last_q;
	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	// state and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						in_ready_q <= 1'b0;
						state_q    <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op == crsm_pkg::OP_MARK && !one_res) begin
						state_q <= ST_APPEND;
					end else begin
						out_valid_q <= 1'b1;
						sel_q       <= 1'b0;
						last_q      <= one_res;
						state_q     <= ST_OUT0;
					end
				end
				ST_APPEND: begin
					out_valid_q <= 1'b1;
					sel_q       <= 1'b0;
					last_q      <= 1'b0;
					state_q     <= ST_OUT0;
				end
				ST_OUT0: begin
					if (out_ready) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							in_ready_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							sel_q   <= 1'b1;
							last_q  <= 1'b1;
							state_q <= ST_OUT1;
						end
					end
				end
				ST_OUT1: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/crsm_dpath.sv
// Pointer datapath: ring positions, fill, lost counters, configuration and
// the two result slots. Driven by crsm_ctrl commands; uses crsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crsm_dpath #(
	parameter int DEPTH = crsm_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [crsm_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [crsm_pkg::CFG_W-1:0]  cfg_data,
	input  wire crsm_pkg::req_t              in_item,
	input  wire crsm_pkg::cmd_t              cmd,
	output crsm_pkg::sts_t                   sts,
	output crsm_pkg::res_t                   out_item
);

	localparam int PW = crsm_pkg::POS_W;
	localparam int NW = crsm_pkg::NEED_W;
	localparam int LW = crsm_pkg::LEN_W;
	localparam int CAP_INIT = (crsm_pkg::CAP_RESET < DEPTH) ? crsm_pkg::CAP_RESET : DEPTH;

	// state
	logic [PW-1:0]               wp_q, rp_q, ve_q;
	logic [LW-1:0]               fill_q;
	logic [crsm_pkg::LOST_W-1:0] lost_q;
	logic [crsm_pkg::MSG_W-1:0]  msgs_q;
	logic [PW-1:0]               cap_q;
	logic [crsm_pkg::MARK_W-1:0] mark_q;
	crsm_pkg::req_t              req_q;
	logic [1:0]                  rkind_q [2];
	logic [PW-1:0]               roff_q  [2];
	logic [LW-1:0]               rlen_q  [2];

	// space search
	logic [NW-1:0] need;
	logic [PW-1:0] room_end;
	logic          fit_ok;
	logic [PW-1:0] fit_pos;

	always_comb begin
		if (lost_q != '0) begin
			need = NW'(req_q.length) + NW'(mark_q) + NW'(1);
		end else begin
			need = NW'(req_q.length) + NW'(req_q.reserve_extra);
		end
		room_end = cap_q - wp_q;
		fit_ok   = 1'b0;
		fit_pos  = wp_q;
		if (wp_q == rp_q) begin
			fit_ok = (fill_q == '0) && (NW'(cap_q) >= need);
		end else if (wp_q > rp_q) begin
			if (NW'(room_end) >= need) begin
				fit_ok = 1'b1;
			end else if (NW'(rp_q) >= need) begin
				fit_ok  = 1'b1;
				fit_pos = '0;
			end
		end else begin
			fit_ok = NW'(rp_q - wp_q) >= need;
		end
	end

	// commit of the granted run
	logic [LW-1:0] n_commit;
	logic          wrap_now;
	logic [PW-1:0] wp_a, ve_a, ve_c, wp_c;
	logic [NW-1:0] wp_b;
	logic [LW-1:0] fill_c;

	always_comb begin
		n_commit = (cmd.op == crsm_pkg::OP_MARK) ? LW'(mark_q) : req_q.length;
		wrap_now = (fit_pos == '0) && (wp_q != '0);
		wp_a     = wrap_now ? '0 : wp_q;
		ve_a     = wrap_now ? (wp_q - PW'(1)) : ve_q;
		wp_b     = NW'(wp_a) + NW'(n_commit);
		fill_c   = fill_q + n_commit;
		ve_c     = ve_a;
		if ((wp_b != '0) && (NW'(ve_a) < (wp_b - NW'(1)))) begin
			ve_c = PW'(wp_b - NW'(1));
		end
		wp_c = (wp_b >= NW'(cap_q)) ? '0 : PW'(wp_b);
	end

	// saturating loss count
	logic [crsm_pkg::LOST_W:0]   loss_sum;
	logic [crsm_pkg::LOST_W-1:0] lost_add;
	logic [crsm_pkg::MSG_W-1:0]  msgs_add;

	always_comb begin
		loss_sum = {1'b0, lost_q} + (crsm_pkg::LOST_W + 1)'(req_q.length);
		lost_add = loss_sum[crsm_pkg::LOST_W] ? '1 : loss_sum[crsm_pkg::LOST_W-1:0];
		msgs_add = (msgs_q == '1) ? msgs_q : msgs_q + 1'b1;
	end

	// read segments
	logic [LW-1:0] size;
	logic [NW-1:0] ve_p1, first, rp_a;
	logic          first_neg, two_seg;
	logic [LW-1:0] seg1;
	logic [PW-1:0] rp_r, wp_r, ve_r;
	logic [LW-1:0] fill_r;

	always_comb begin
		size      = (fill_q < req_q.length) ? fill_q : req_q.length;
		ve_p1     = NW'(ve_q) + NW'(1);
		first_neg = ve_p1 < NW'(rp_q);
		first     = ve_p1 - NW'(rp_q);
		two_seg   = (wp_q <= rp_q) && !first_neg && (first < NW'(size));
		seg1      = size - LW'(first);
		if (two_seg) begin
			rp_a = NW'(seg1);
		end else begin
			rp_a = NW'(rp_q) + NW'(size);
			if ((rp_a == ve_p1) && (rp_a != NW'(wp_q))) begin
				rp_a = '0;
			end
		end
		fill_r = fill_q - size;
		ve_r   = (rp_a < NW'(wp_q)) ? (wp_q - PW'(1)) : ve_q;
		rp_r   = PW'(rp_a);
		wp_r   = wp_q;
		if (rp_a == NW'(wp_q)) begin
			rp_r = '0;
			wp_r = '0;
			ve_r = '0;
		end
	end

	// status to the controller
	assign sts.len_zero  = (req_q.length == '0);
	assign sts.is_read   = (req_q.kind == crsm_pkg::KIND_READ);
	assign sts.fill_zero = (fill_q == '0);
	assign sts.lost_nz   = (lost_q != '0);
	assign sts.mark_fits = fit_ok;
	assign sts.two_seg   = two_seg;

	// configuration clamps
	logic [PW-1:0]               cap_clamp;
	logic [crsm_pkg::MARK_W-1:0] mark_clamp;

	always_comb begin
		if (cfg_data == '0) begin
			cap_clamp = PW'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cap_clamp = PW'(DEPTH);
		end else begin
			cap_clamp = PW'(cfg_data);
		end
		if (cfg_data[crsm_pkg::MARK_W-1:0] == '0) begin
			mark_clamp = crsm_pkg::MARK_W'(1);
		end else if (cfg_data[crsm_pkg::MARK_W-1:0] > crsm_pkg::MARK_W'(crsm_pkg::MARK_MAX)) begin
			mark_clamp = crsm_pkg::MARK_W'(crsm_pkg::MARK_MAX);
		end else begin
			mark_clamp = cfg_data[crsm_pkg::MARK_W-1:0];
		end
	end

	// control state: pointers, counters, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			ve_q   <= '0;
			fill_q <= '0;
			lost_q <= '0;
			msgs_q <= '0;
			cap_q  <= PW'(CAP_INIT);
			mark_q <= crsm_pkg::MARK_W'(crsm_pkg::MARK_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				crsm_pkg::REG_CAPACITY: begin
					cap_q  <= cap_clamp;
					wp_q   <= '0;
					rp_q   <= '0;
					ve_q   <= '0;
					fill_q <= '0;
				end
				crsm_pkg::REG_MARKER: begin
					mark_q <= mark_clamp;
				end
				default: begin
					mark_q <= mark_q;
				end
			endcase
		end else begin
			case (cmd.op)
				crsm_pkg::OP_MARK, crsm_pkg::OP_APPEND: begin
					if (fit_ok) begin
						wp_q   <= wp_c;
						ve_q   <= ve_c;
						fill_q <= fill_c;
						if (cmd.op == crsm_pkg::OP_MARK) begin
							lost_q <= '0;
							msgs_q <= '0;
						end
					end else begin
						lost_q <= lost_add;
						msgs_q <= msgs_add;
					end
				end
				crsm_pkg::OP_READ: begin
					wp_q   <= wp_r;
					rp_q   <= rp_r;
					ve_q   <= ve_r;
					fill_q <= fill_r;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	// request latch and result slots
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_item;
		end
		case (cmd.op)
			crsm_pkg::OP_EMPTY: begin
				rkind_q[cmd.slot] <= crsm_pkg::RK_NONE;
				roff_q[cmd.slot]  <= '0;
				rlen_q[cmd.slot]  <= '0;
			end
			crsm_pkg::OP_MARK, crsm_pkg::OP_APPEND: begin
				if (fit_ok) begin
					rkind_q[cmd.slot] <= (cmd.op == crsm_pkg::OP_MARK) ?
						crsm_pkg::RK_MARK : crsm_pkg::RK_WRITE;
					roff_q[cmd.slot]  <= fit_pos;
					rlen_q[cmd.slot]  <= n_commit;
				end else begin
					rkind_q[cmd.slot] <= crsm_pkg::RK_NONE;
					roff_q[cmd.slot]  <= '0;
					rlen_q[cmd.slot]  <= '0;
				end
			end
			crsm_pkg::OP_READ: begin
				rkind_q[0] <= crsm_pkg::RK_READ;
				roff_q[0]  <= rp_q;
				rlen_q[0]  <= two_seg ? LW'(first) : size;
				rkind_q[1] <= crsm_pkg::RK_READ;
				roff_q[1]  <= '0;
				rlen_q[1]  <= seg1;
			end
			default: begin
				// slots hold while results are shown
			end
		endcase
	end

	// result item: slot fields plus state after the whole step
	assign out_item.result_kind     = rkind_q[cmd.sel];
	assign out_item.offset          = roff_q[cmd.sel][crsm_pkg::OFF_W-1:0];
	assign out_item.seg_length      = rlen_q[cmd.sel];
	assign out_item.lost_byte_count = lost_q;
	assign out_item.fill_level      = fill_q;
	assign out_item.last            = cmd.last;

endmodule
`default_nettype wire

// File: rtl/contiguous_ring_space_manager.sv
// Contiguous ring space manager: grants unsplit append runs, lost-report
// markers and one or two read segments. Items are handled one at a time:
// accept, a decide state (plus an append state after a granted marker), then
// one or two result states, which wait while the result side stalls. Reset
// clears pointers, fill and lost counters at once; capacity resets to 4096
// (or DEPTH if smaller) and marker length to 32.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_ring_space_manager #(
	parameter int DEPTH = crsm_pkg::DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [crsm_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [crsm_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire crsm_pkg::req_t              in_item,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output crsm_pkg::res_t                   out_item
);

	crsm_pkg::cmd_t cmd;
	crsm_pkg::sts_t sts;

	// sequencer
	crsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// pointer datapath
	crsm_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

`ifndef SYNTH
	// one item at a time: never ready while a result is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("in_ready and out_valid both high");

	// after the final result is taken the block is ready again
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_item.last) |=> in_ready)
		else $error("not ready after final result");

	// a marker grant is always followed by a second result
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.result_kind == crsm_pkg::RK_MARK) |-> !out_item.last)
		else $error("marker grant flagged last");

	// refusals carry no segment
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.result_kind == crsm_pkg::RK_NONE) |->
		(out_item.seg_length == '0 && out_item.offset == '0))
		else $error("refusal with nonzero segment");
`endif

endmodule
`default_nettype wire

// File: verif/contiguous_ring_space_manager_tb.sv
// Self-checking testbench for the contiguous ring space manager.
// Drives append/read requests and register writes, predicts every result item
// in a local ring model; depends on crsm_pkg and contiguous_ring_space_manager.
`timescale 1ns / 1ps
module contiguous_ring_space_manager_tb;

	localparam int RING_DEPTH    = crsm_pkg::DEPTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 200;
	localparam int PRINT_LIMIT   = 40;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [crsm_pkg::CIDX_W-1:0] cfg_index = '0;
	logic [crsm_pkg::CFG_W-1:0]  cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	crsm_pkg::req_t              in_item = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	crsm_pkg::res_t              out_item;

	// ring model state and its registers
	logic [crsm_pkg::POS_W-1:0]  ring_cap;
	logic [crsm_pkg::MARK_W-1:0] ring_mark;
	logic [crsm_pkg::POS_W-1:0]  ring_wr;
	logic [crsm_pkg::POS_W-1:0]  ring_rd;
	logic [crsm_pkg::OFF_W-1:0]  ring_end;
	logic [crsm_pkg::LEN_W-1:0]  ring_fill;
	logic [crsm_pkg::LOST_W-1:0] ring_lost;
	logic [crsm_pkg::MSG_W-1:0]  ring_lost_msgs;

	crsm_pkg::res_t pending_results[$];
	int   mismatch_count = 0;
	int   stall_cycles = 0;
	bit   no_idle = 1'b0;
	int   rx_hold_req = 0;
	int   rx_left = 0;

	contiguous_ring_space_manager u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	// ---------------------------------------------------------------- model

	function automatic void empty_ring();
		ring_wr   = '0;
		ring_rd   = '0;
		ring_end  = '0;
		ring_fill = '0;
	endfunction

	// contiguous run of need bytes at the write position or at byte 0
	function automatic bit fit_run(input int unsigned need, output int unsigned start);
		start = 0;
		if (need == 0)
			return 1'b0;
		if (ring_wr == ring_rd) begin
			if (ring_fill == 0 && ring_cap >= need) begin
				start = 32'(ring_wr);
				return 1'b1;
			end
			return 1'b0;
		end
		if (ring_wr > ring_rd) begin
			if (32'(ring_cap) - 32'(ring_wr) >= need) begin
				start = 32'(ring_wr);
				return 1'b1;
			end
			if (ring_rd >= need)
				return 1'b1;
			return 1'b0;
		end
		if (32'(ring_rd) - 32'(ring_wr) >= need) begin
			start = 32'(ring_wr);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// early wrap marks the old write position minus one as the valid end
	function automatic void commit_run(input int unsigned start, input int unsigned n);
		if (start == 0 && ring_wr != 0) begin
			ring_end = crsm_pkg::OFF_W'(32'(ring_wr) - 32'd1);
			ring_wr  = '0;
		end
		ring_wr   = crsm_pkg::POS_W'(32'(ring_wr) + n);
		ring_fill = crsm_pkg::LEN_W'(32'(ring_fill) + n);
		if (ring_wr > 0 && 32'(ring_end) < 32'(ring_wr) - 32'd1)
			ring_end = crsm_pkg::OFF_W'(32'(ring_wr) - 32'd1);
		if (ring_wr >= ring_cap)
			ring_wr = '0;
	endfunction

	function automatic void count_loss(input int unsigned n);
		if (n > 32'hFFFF_FFFF - ring_lost)
			ring_lost = '1;
		else
			ring_lost = crsm_pkg::LOST_W'(ring_lost + n);
		if (ring_lost_msgs != 16'hFFFF)
			ring_lost_msgs = ring_lost_msgs + 16'd1;
	endfunction

	function automatic crsm_pkg::res_t make_res(input logic [1:0] k, input int unsigned off,
			input int unsigned len);
		crsm_pkg::res_t x;
		x = '0;
		x.result_kind = k;
		x.offset      = crsm_pkg::OFF_W'(off);
		x.seg_length  = crsm_pkg::LEN_W'(len);
		return x;
	endfunction

	// expected result items of one accepted request
	function automatic void predict_step(input crsm_pkg::req_t r);
		crsm_pkg::res_t step_q[$];
		crsm_pkg::res_t one;
		int unsigned    at, size, first, len;
		bit             placed;
		len = 32'(r.length);
		if (len == 0) begin
			step_q.push_back(make_res(crsm_pkg::RK_NONE, 0, 0));
		end else if (r.kind == crsm_pkg::KIND_APPEND) begin
			placed = 1'b1;
			// pending losses need a report marker ahead of the append
			if (ring_lost != 0) begin
				if (fit_run(len + 32'(ring_mark) + 32'd1, at)) begin
					ring_lost      = '0;
					ring_lost_msgs = '0;
					commit_run(at, 32'(ring_mark));
					step_q.push_back(make_res(crsm_pkg::RK_MARK, at, 32'(ring_mark)));
				end else begin
					count_loss(len);
					step_q.push_back(make_res(crsm_pkg::RK_NONE, 0, 0));
					placed = 1'b0;
				end
			end
			if (placed) begin
				if (fit_run(len + 32'(r.reserve_extra), at)) begin
					commit_run(at, len);
					step_q.push_back(make_res(crsm_pkg::RK_WRITE, at, len));
				end else begin
					count_loss(len);
					step_q.push_back(make_res(crsm_pkg::RK_NONE, 0, 0));
				end
			end
		end else if (ring_fill == 0) begin
			step_q.push_back(make_res(crsm_pkg::RK_NONE, 0, 0));
		end else begin
			size  = (32'(ring_fill) < len) ? 32'(ring_fill) : len;
			first = 32'(ring_end) - 32'(ring_rd) + 32'd1;
			if (ring_wr <= ring_rd && first < size) begin
				// readable data wraps past the valid end
				step_q.push_back(make_res(crsm_pkg::RK_READ, 32'(ring_rd), first));
				step_q.push_back(make_res(crsm_pkg::RK_READ, 0, size - first));
				ring_rd = crsm_pkg::POS_W'(size - first);
			end else begin
				step_q.push_back(make_res(crsm_pkg::RK_READ, 32'(ring_rd), size));
				ring_rd = crsm_pkg::POS_W'(32'(ring_rd) + size);
				if (32'(ring_rd) == 32'(ring_end) + 32'd1 && ring_rd != ring_wr)
					ring_rd = '0;
			end
			ring_fill = crsm_pkg::LEN_W'(32'(ring_fill) - size);
			if (ring_rd < ring_wr)
				ring_end = crsm_pkg::OFF_W'(32'(ring_wr) - 32'd1);
			if (ring_rd == ring_wr) begin
				ring_rd  = '0;
				ring_wr  = '0;
				ring_end = '0;
			end
		end
		foreach (step_q[i]) begin
			one = step_q[i];
			one.lost_byte_count = ring_lost;
			one.fill_level      = ring_fill;
			one.last            = (i == step_q.size() - 1);
			pending_results.push_back(one);
		end
	endfunction

	// ------------------------------------------------------------ stimulus

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic crsm_pkg::req_t make_req(input logic k, input int unsigned len,
			input logic x);
		crsm_pkg::req_t r;
		r.kind          = k;
		r.length        = crsm_pkg::LEN_W'(len);
		r.reserve_extra = x;
		return r;
	endfunction

	// lengths scaled to the ring, with zero, oversize and full-range ones mixed in
	function automatic crsm_pkg::req_t pick_request();
		crsm_pkg::req_t r;
		int unsigned    sel, lim;
		r.kind = ($urandom_range(0, 99) < 45) ? crsm_pkg::KIND_READ : crsm_pkg::KIND_APPEND;
		r.reserve_extra = 1'($urandom_range(0, 1));
		lim = (r.kind == crsm_pkg::KIND_READ) ? 32'(ring_cap) / 2 + 1 : 32'(ring_cap) / 3 + 1;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			r.length = '0;
		else if (sel < 9)
			r.length = crsm_pkg::LEN_W'($urandom_range(0, 8191));
		else if (sel < 13)
			r.length = crsm_pkg::LEN_W'(32'(ring_cap) + $urandom_range(0, 4));
		else
			r.length = crsm_pkg::LEN_W'($urandom_range(1, lim));
		return r;
	endfunction

	// offer one item after a random gap, predict once it is taken
	task automatic send_req(input crsm_pkg::req_t r);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item  <= r;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_step(r);
	endtask

	task automatic run_random(input int count);
		repeat (count) send_req(pick_request());
	endtask

	// stop offering and wait for every expected item, then let the block settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [crsm_pkg::CIDX_W-1:0] idx,
			input logic [crsm_pkg::CFG_W-1:0] value);
		logic [crsm_pkg::MARK_W-1:0] m;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == crsm_pkg::REG_CAPACITY) begin
			if (value == 0)
				ring_cap = crsm_pkg::POS_W'(1);
			else if (value > RING_DEPTH)
				ring_cap = crsm_pkg::POS_W'(RING_DEPTH);
			else
				ring_cap = crsm_pkg::POS_W'(value);
			empty_ring();
		end else begin
			m = value[crsm_pkg::MARK_W-1:0];
			if (m == 0)
				ring_mark = crsm_pkg::MARK_W'(1);
			else if (m > crsm_pkg::MARK_MAX)
				ring_mark = crsm_pkg::MARK_W'(crsm_pkg::MARK_MAX);
			else
				ring_mark = m;
		end
		@(posedge clk);
	endtask

	task automatic run_phase(input int cap, input int mark, input int count);
		drain_results();
		write_reg(crsm_pkg::REG_CAPACITY, crsm_pkg::CFG_W'(cap));
		write_reg(crsm_pkg::REG_MARKER, crsm_pkg::CFG_W'(mark));
		run_random(count);
	endtask

	// --------------------------------------------------------------- tests

	// reset settings: full ring, full-length read, wrap at the top byte, marker
	task automatic test_reset_defaults();
		send_req(make_req(crsm_pkg::KIND_READ, 8191, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 4096, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 1, 1'b1));
		send_req(make_req(crsm_pkg::KIND_READ, 4095, 1'b0));
		send_req(make_req(crsm_pkg::KIND_READ, 100, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 4096, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 100, 1'b0));
	endtask

	// small ring: zero lengths, refusals, marker granted and not, two segments
	task automatic test_small_ring_cases();
		drain_results();
		write_reg(crsm_pkg::REG_CAPACITY, crsm_pkg::CFG_W'(16));
		write_reg(crsm_pkg::REG_MARKER, crsm_pkg::CFG_W'(4));
		send_req(make_req(crsm_pkg::KIND_READ, 5, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 0, 1'b1));
		send_req(make_req(crsm_pkg::KIND_READ, 0, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 10, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 6, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 2, 1'b0));
		send_req(make_req(crsm_pkg::KIND_READ, 7, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 1, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 3, 1'b1));
		send_req(make_req(crsm_pkg::KIND_READ, 16, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 16, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 1, 1'b0));
		send_req(make_req(crsm_pkg::KIND_READ, 16, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 20, 1'b0));
		send_req(make_req(crsm_pkg::KIND_APPEND, 8191, 1'b1));
		send_req(make_req(crsm_pkg::KIND_APPEND, 5, 1'b0));
	endtask

	// clamped and limit register values
	task automatic test_register_extremes();
		run_phase(0, 0, 40);
		run_phase(8191, 127, 80);
		run_phase(4096, 64, 60);
		run_phase(1, 1, 40);
	endtask

	task automatic test_random_rings();
		repeat (7) begin
			if ($urandom_range(0, 3) == 0)
				run_phase($urandom_range(0, 8191), $urandom_range(0, 127), 100);
			else
				run_phase($urandom_range(2, 300), $urandom_range(1, 64), 100);
		end
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_output_backpressure();
		run_phase(64, 6, 10);
		no_idle     = 1'b1;
		rx_hold_req = HOLD_CYCLES;
		run_random(50);
		no_idle = 1'b0;
	endtask

	// sender waits for every result mid-phase, then a stretch without idling
	task automatic test_sender_pause();
		run_phase(40, 3, 40);
		drain_results();
		run_random(40);
		no_idle = 1'b1;
		run_random(60);
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------ checking

	task automatic report_mismatch(input string field, input longint unsigned got,
			input longint unsigned want);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		crsm_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result item", out_item.result_kind, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_item.result_kind !== want.result_kind)
					report_mismatch("result_kind", out_item.result_kind, want.result_kind);
				if (out_item.offset !== want.offset)
					report_mismatch("offset", out_item.offset, want.offset);
				if (out_item.seg_length !== want.seg_length)
					report_mismatch("seg_length", out_item.seg_length, want.seg_length);
				if (out_item.lost_byte_count !== want.lost_byte_count)
					report_mismatch("lost_byte_count", out_item.lost_byte_count,
						want.lost_byte_count);
				if (out_item.fill_level !== want.fill_level)
					report_mismatch("fill_level", out_item.fill_level, want.fill_level);
				if (out_item.last !== want.last)
					report_mismatch("last", out_item.last, want.last);
			end
		end
	end

	// result side pacing: long hold on request, random gaps otherwise
	always @(posedge clk) begin : rx_pace
		int g;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_req > 0) begin
			rx_left = rx_hold_req - 1;
			rx_hold_req = 0;
			out_ready <= 1'b0;
		end else if (rx_left > 0) begin
			rx_left--;
			out_ready <= 1'b0;
		end else if (no_idle) begin
			out_ready <= 1'b1;
		end else begin
			g = pick_gap();
			if (g == 0) begin
				out_ready <= 1'b1;
			end else begin
				rx_left = g - 1;
				out_ready <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------ sequence

	initial begin
		ring_cap       = crsm_pkg::POS_W'(crsm_pkg::CAP_RESET);
		ring_mark      = crsm_pkg::MARK_W'(crsm_pkg::MARK_RESET);
		ring_lost      = '0;
		ring_lost_msgs = '0;
		empty_ring();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_small_ring_cases();
		test_register_extremes();
		test_random_rings();
		test_output_backpressure();
		test_sender_pause();

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: contiguous_ring_space_manager.f
rtl/crsm_pkg.sv
rtl/crsm_ctrl.sv
rtl/crsm_dpath.sv
rtl/contiguous_ring_space_manager.sv
verif/contiguous_ring_space_manager_tb.sv
